// ===== design/spl_pkg.sv =====
// ----------------------------------------------------------------------------
// Stereo peak limiter package
// Register widths, register indexes, reset values and the sequencer states.
// ----------------------------------------------------------------------------
package spl_pkg;

  localparam int unsigned REG_W      = 24;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned COEF_FRAC  = 24;

  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CEILING   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_RELEASE   = 2'd2;

  localparam logic [REG_W-1:0] THRESHOLD_RST = 24'd8388608;
  localparam logic [REG_W-1:0] CEILING_RST   = 24'd8388608;
  localparam logic [REG_W-1:0] RELEASE_RST   = 24'd16773721;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_REL,
    ST_REL_WB,
    ST_MUL_L,
    ST_MUL_R,
    ST_DONE
  } spl_state_e;

endpackage

// ===== design/spl_in_if.sv =====
// ----------------------------------------------------------------------------
// Stereo sample input channel
// Valid/ready channel carrying one stereo sample pair per item.
// ----------------------------------------------------------------------------
interface spl_in_if #(
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// ===== design/spl_out_if.sv =====
// ----------------------------------------------------------------------------
// Limited sample output channel
// Valid/ready channel carrying one limited stereo pair per item.
// ----------------------------------------------------------------------------
interface spl_out_if #(
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ===== design/spl_divider.sv =====
// ----------------------------------------------------------------------------
// Limiter gain divider
// Restoring divider, one quotient bit per cycle: (dividend << GAIN_FRAC_BITS)
// divided by the divisor, for a dividend below the divisor.
// ----------------------------------------------------------------------------
module spl_divider #(
  parameter int unsigned SAMPLE_BITS    = 24,
  parameter int unsigned GAIN_FRAC_BITS = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [SAMPLE_BITS-1:0]    dividend_i,
  input  logic [SAMPLE_BITS-1:0]    divisor_i,
  output logic [GAIN_FRAC_BITS-1:0] quotient_o,
  output logic                      done_o
);

  localparam int unsigned S  = SAMPLE_BITS;
  localparam int unsigned G  = GAIN_FRAC_BITS;
  localparam int unsigned CW = $clog2(G);
  localparam logic [CW-1:0] LAST_STEP = CW'(G - 1);

  logic [S:0]    rem_q, rem_d;
  logic [S-1:0]  dvs_q, dvs_d;
  logic [G-1:0]  quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [S:0]    shifted;
  logic          fits;

  assign shifted = {rem_q[S-1:0], 1'b0};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = {1'b0, dividend_i};
      dvs_d  = divisor_i;
      quo_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? (shifted - {1'b0, dvs_q}) : shifted;
      quo_d = {quo_q[G-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// ===== design/stereo_peak_limiter.sv =====
// ----------------------------------------------------------------------------
// Stereo peak limiter
// Stereo-linked peak limiter with instant attack and exponential release.
// ----------------------------------------------------------------------------
// Usage: one stereo pair enters per item on smp_i and one limited pair leaves
// on lim_o, both valid/ready channels. The host sets threshold, ceiling and
// release coefficient through the write port (cfg_we_i, cfg_addr_i,
// cfg_wdata_i) while no item is in flight.
// Timing: an item whose peak stays at or below the threshold passes through
// the release, release write-back, left, right and done states before the
// next possible acceptance; one that needs a new target gain also runs the
// restoring divider first, and skips the release write-back when the new
// gain is below the current one and is taken at once. The divider and the
// single shared multiplier, used in turn for release, left and right, set
// the pace of the sequencer.
// A finished pair sits in the output register, so the next item is taken
// while it waits; if the receiver still stalls when the following result is
// ready, the sequencer holds it and accepts nothing further.
// Reset restores unity gain and the register defaults and empties the output.
// ----------------------------------------------------------------------------
module stereo_peak_limiter
  import spl_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS    = 24,
  parameter int unsigned GAIN_FRAC_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [REG_W-1:0]      cfg_wdata_i,
  spl_in_if.sink                smp_i,
  spl_out_if.source             lim_o
);

  localparam int unsigned S  = SAMPLE_BITS;
  localparam int unsigned G  = GAIN_FRAC_BITS;
  localparam int unsigned LW = ((S > REG_W) ? S : REG_W) + 1;
  localparam int unsigned AW = (S > G + 1) ? S : G + 1;
  localparam int unsigned BW = (REG_W > G + 1) ? REG_W : G + 1;
  localparam int unsigned PW = AW + BW;

  localparam logic [G:0]    UNITY   = (G + 1)'(1) << G;
  localparam logic [S-1:0]  FS      = S'(1) << (S - 1);
  localparam logic [LW-1:0] FS_EXT  = LW'(1) << (S - 1);

  spl_state_e state_q, state_d;

  logic [REG_W-1:0] thr_q, ceil_q, coef_q;
  logic [S-1:0]     thr_sat, ceil_sat;
  logic [LW-1:0]    thr_ext, ceil_ext;

  logic [G:0]   gain_q, gain_d;
  logic [G:0]   target_q, target_d;
  logic [S-1:0] mag_l_q, mag_l_d, mag_r_q, mag_r_d;
  logic         neg_l_q, neg_l_d, neg_r_q, neg_r_d;
  logic [S-1:0] res_l_q, res_l_d;

  logic [S-1:0] raw_l, raw_r, mag_l_c, mag_r_c, peak_c;

  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [PW-1:0] prod_q, prod_d;
  logic          prod_en;
  logic [G:0]    diff;

  logic         out_valid_q, out_valid_d;
  logic [S-1:0] left_out_q, left_out_d, right_out_q, right_out_d;

  logic         div_start;
  logic [G-1:0] div_quo;
  logic         div_done;

  // Output clamp: negative results may reach the full ceiling, positive ones
  // stop at the ceiling, or one code short of full scale if that is lower.
  function automatic logic [S-1:0] clamp_out(input logic [S-1:0] mag,
                                             input logic         neg,
                                             input logic [S-1:0] ceil_mag);
    logic [S-1:0] pos_lim;
    logic [S-1:0] lim;
    pos_lim = (ceil_mag < FS) ? ceil_mag : (FS - 1'b1);
    if (neg) begin
      lim = (mag > ceil_mag) ? ceil_mag : mag;
      return ~lim + 1'b1;
    end
    return (mag > pos_lim) ? pos_lim : mag;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THRESHOLD_RST;
      ceil_q <= CEILING_RST;
      coef_q <= RELEASE_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_THRESHOLD: thr_q  <= cfg_wdata_i;
        CFG_CEILING:   ceil_q <= cfg_wdata_i;
        CFG_RELEASE:   coef_q <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  assign thr_ext  = LW'(thr_q);
  assign ceil_ext = LW'(ceil_q);
  assign thr_sat  = (thr_ext > FS_EXT) ? FS : S'(thr_ext);
  assign ceil_sat = (ceil_ext > FS_EXT) ? FS : S'(ceil_ext);

  // The most negative sample negates to itself, which read unsigned is full scale.
  assign raw_l   = smp_i.left_sample;
  assign raw_r   = smp_i.right_sample;
  assign mag_l_c = raw_l[S-1] ? (~raw_l + 1'b1) : raw_l;
  assign mag_r_c = raw_r[S-1] ? (~raw_r + 1'b1) : raw_r;
  assign peak_c  = (mag_l_c > mag_r_c) ? mag_l_c : mag_r_c;

  assign diff = target_q - gain_q;

  spl_divider #(
    .SAMPLE_BITS    (S),
    .GAIN_FRAC_BITS (G)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (thr_sat),
    .divisor_i  (peak_c),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  // Shared multiplier: release product, then left, then right.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    prod_en = 1'b0;
    case (state_q)
      ST_REL: begin
        mul_a   = AW'(diff);
        mul_b   = BW'(coef_q);
        prod_en = 1'b1;
      end
      ST_MUL_L: begin
        mul_a   = AW'(mag_l_q);
        mul_b   = BW'(gain_q);
        prod_en = 1'b1;
      end
      ST_MUL_R: begin
        mul_a   = AW'(mag_r_q);
        mul_b   = BW'(gain_q);
        prod_en = 1'b1;
      end
      default: ;
    endcase
  end

  assign prod_d = PW'(mul_a) * PW'(mul_b);

  always_comb begin
    state_d     = state_q;
    gain_d      = gain_q;
    target_d    = target_q;
    mag_l_d     = mag_l_q;
    mag_r_d     = mag_r_q;
    neg_l_d     = neg_l_q;
    neg_r_d     = neg_r_q;
    res_l_d     = res_l_q;
    left_out_d  = left_out_q;
    right_out_d = right_out_q;
    out_valid_d = out_valid_q && !lim_o.ready;
    div_start   = 1'b0;
    smp_i.ready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        smp_i.ready = 1'b1;
        if (smp_i.valid) begin
          mag_l_d = mag_l_c;
          mag_r_d = mag_r_c;
          neg_l_d = raw_l[S-1];
          neg_r_d = raw_r[S-1];
          if (peak_c > thr_sat) begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end else begin
            target_d = UNITY;
            state_d  = ST_REL;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          target_d = {1'b0, div_quo};
          state_d  = ST_REL;
        end
      end
      ST_REL: begin
        // Attack is instant; release goes through the multiplier.
        if (target_q < gain_q) begin
          gain_d  = target_q;
          state_d = ST_MUL_L;
        end else begin
          state_d = ST_REL_WB;
        end
      end
      ST_REL_WB: begin
        gain_d  = target_q - prod_q[COEF_FRAC +: G + 1];
        state_d = ST_MUL_L;
      end
      ST_MUL_L: begin
        state_d = ST_MUL_R;
      end
      ST_MUL_R: begin
        res_l_d = clamp_out(prod_q[G +: S], neg_l_q, ceil_sat);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || lim_o.ready) begin
          out_valid_d = 1'b1;
          left_out_d  = res_l_q;
          right_out_d = clamp_out(prod_q[G +: S], neg_r_q, ceil_sat);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gain_q      <= UNITY;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gain_q      <= gain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q    <= target_d;
    mag_l_q     <= mag_l_d;
    mag_r_q     <= mag_r_d;
    neg_l_q     <= neg_l_d;
    neg_r_q     <= neg_r_d;
    res_l_q     <= res_l_d;
    left_out_q  <= left_out_d;
    right_out_q <= right_out_d;
    if (prod_en) begin
      prod_q <= prod_d;
    end
  end

  assign lim_o.valid     = out_valid_q;
  assign lim_o.left_out  = $signed(left_out_q);
  assign lim_o.right_out = $signed(right_out_q);

  a_gain_below_unity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_q <= UNITY)
    else $error("limiter gain rose above unity");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (smp_i.valid && smp_i.ready) |=> !smp_i.ready)
    else $error("limiter took a second item while busy");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("output loaded outside the final step");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished while the sequencer was not waiting");

  a_release_not_attack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REL_WB) |-> (target_q >= gain_q))
    else $error("release step entered with a target below the gain");

endmodule
